>>> hw/rtl/crlt_pkg.sv
// Shared constants, widths and the arctangent table for the radius / local time converter.
`default_nettype none

package crlt_pkg;

    // Coordinate format
    localparam int COORD_WIDTH    = 16;
    localparam int CORDIC_STAGES  = 16;
    localparam int MAX_STAGES     = 24;

    // Angle datapath: coordinates are scaled up before rotation
    localparam int PRESCALE_SHIFT = 16;
    localparam int CORDIC_W       = COORD_WIDTH + PRESCALE_SHIFT + 3;

    // Hours carry ANGLE_FRAC fraction bits inside, TIME_FRAC at the port
    localparam int ANGLE_FRAC     = 20;
    localparam int TIME_FRAC      = 12;
    localparam int ROUND_SHIFT    = ANGLE_FRAC - TIME_FRAC;
    localparam int TIME_W         = 17;
    localparam int ANGLE_W        = TIME_W + ROUND_SHIFT + 1;

    // One pipeline stage per CORDIC rotation and per square root digit
    localparam int ITER_STAGES    = (CORDIC_STAGES > COORD_WIDTH) ? CORDIC_STAGES : COORD_WIDTH;

    // Stream widths, fields packed from bit 0 and padded to whole bytes
    localparam int IN_TDATA_W     = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W    = ((COORD_WIDTH + TIME_W + 7) / 8) * 8;

    localparam logic signed [ANGLE_W-1:0] HALF_TURN  = ANGLE_W'(12 <<< ANGLE_FRAC);
    localparam logic signed [ANGLE_W-1:0] FULL_TURN  = ANGLE_W'(24 <<< ANGLE_FRAC);
    localparam logic [ANGLE_W-2:0]        TIME_ROUND = (ANGLE_W-1)'(1 << (ROUND_SHIFT - 1));
    localparam logic [TIME_W-1:0]         TIME_LIMIT  = TIME_W'(24 << TIME_FRAC);
    localparam logic [TIME_W-1:0]         TIME_ORIGIN = TIME_W'(12 << TIME_FRAC);

    // atan(2^-i) in hours, ANGLE_FRAC fraction bits, rounded to nearest
    localparam logic signed [ANGLE_W-1:0] ATAN_HOURS [MAX_STAGES] = '{
        26'sd3145728, 26'sd1857032, 26'sd981205, 26'sd498075,
        26'sd250004,  26'sd125124,  26'sd62577,  26'sd31290,
        26'sd15645,   26'sd7823,    26'sd3911,   26'sd1956,
        26'sd978,     26'sd489,     26'sd244,    26'sd122,
        26'sd61,      26'sd31,      26'sd15,     26'sd8,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

    // Payload of one stage of the rotation / square root bank
    typedef struct packed {
        logic signed [CORDIC_W-1:0] u;
        logic signed [CORDIC_W-1:0] v;
        logic signed [ANGLE_W-1:0]  z;
        logic [2*COORD_WIDTH-1:0]   sq;
        logic [COORD_WIDTH+1:0]     rem;
        logic [COORD_WIDTH-1:0]     root;
        logic                       origin;
        logic                       last;
    } iter_t;

endpackage

`default_nettype wire

>>> hw/rtl/cartesian_to_radius_local_time_core.sv
// Top level: pipelined radius and local time converter for signed fixed-point points.
`default_nettype none

// Takes one point (x, y) per cycle unless the output stalls and returns sqrt(x^2 + y^2), rounded
// to nearest in the input scale, and the angle of (-x, -y) as local time in hours [0, 24) with
// 12 fraction bits; the origin gives 12 hours. Throughput is one point per clock unless the
// output stalls. The pipeline has one stage for the squares and prescale, one for the sum, one
// stage per CORDIC rotation and square root digit, which run side by side, then one stage to
// round the radius and wrap the angle, and the output register that rounds the time. Every
// stage has its own valid bit and empties into the next on its own, so bubbles close up and a
// stalled output holds data without loss.
module cartesian_to_radius_local_time_core (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [crlt_pkg::IN_TDATA_W-1:0]      s_tdata,   // x_pos, y_pos
    input  wire                                  s_tlast,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [crlt_pkg::OUT_TDATA_W-1:0]     m_tdata,   // radial_distance, local_time_hours, zero pad
    output logic                                 m_tlast
);

    import crlt_pkg::*;

    localparam int W = COORD_WIDTH;

    // ---------------- input fields ----------------
    logic signed [W-1:0]        x_pos;
    logic signed [W-1:0]        y_pos;
    logic signed [CORDIC_W-1:0] x_ext;
    logic signed [CORDIC_W-1:0] y_ext;

    assign x_pos = $signed(s_tdata[W-1:0]);
    assign y_pos = $signed(s_tdata[2*W-1:W]);
    assign x_ext = CORDIC_W'(x_pos);
    assign y_ext = CORDIC_W'(y_pos);

    // ---------------- ready chain ----------------
    logic                 out_ready;
    logic                 f_ready;
    logic                 a_ready;
    logic [ITER_STAGES:0] iter_ready;

    // ---------------- stage A: squares and prescale ----------------
    logic                       a_valid_reg;
    logic [2*W-1:0]             a_xx_reg, a_xx_next;
    logic [2*W-1:0]             a_yy_reg, a_yy_next;
    logic signed [CORDIC_W-1:0] a_u_reg, a_u_next;
    logic signed [CORDIC_W-1:0] a_v_reg, a_v_next;
    logic signed [ANGLE_W-1:0]  a_z_reg, a_z_next;
    logic                       a_origin_reg;
    logic                       a_last_reg;
    logic signed [2*W-1:0]      xx_full;
    logic signed [2*W-1:0]      yy_full;

    assign xx_full = (2*W)'(x_pos) * (2*W)'(x_pos);
    assign yy_full = (2*W)'(y_pos) * (2*W)'(y_pos);

    always_comb
    begin
        a_xx_next = xx_full;
        a_yy_next = yy_full;
        // Point (-x, -y) into the right half plane; record half a turn when it is flipped
        if (x_pos > 0)
        begin
            a_u_next = x_ext <<< PRESCALE_SHIFT;
            a_v_next = y_ext <<< PRESCALE_SHIFT;
            a_z_next = HALF_TURN;
        end
        else
        begin
            a_u_next = (-x_ext) <<< PRESCALE_SHIFT;
            a_v_next = (-y_ext) <<< PRESCALE_SHIFT;
            a_z_next = '0;
        end
    end

    assign a_ready  = !a_valid_reg || iter_ready[0];
    assign s_tready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_ready)
            a_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && s_tvalid)
        begin
            a_xx_reg     <= a_xx_next;
            a_yy_reg     <= a_yy_next;
            a_u_reg      <= a_u_next;
            a_v_reg      <= a_v_next;
            a_z_reg      <= a_z_next;
            a_origin_reg <= (x_pos == '0) && (y_pos == '0);
            a_last_reg   <= s_tlast;
        end
    end

    // ---------------- rotation / square root bank ----------------
    iter_t                iter_reg  [ITER_STAGES+1];
    iter_t                iter_next [ITER_STAGES+1];
    logic [ITER_STAGES:0] iter_valid_reg;

    always_comb
    begin
        iter_next[0].u      = a_u_reg;
        iter_next[0].v      = a_v_reg;
        iter_next[0].z      = a_z_reg;
        iter_next[0].sq     = a_xx_reg + a_yy_reg;
        iter_next[0].rem    = '0;
        iter_next[0].root   = '0;
        iter_next[0].origin = a_origin_reg;
        iter_next[0].last   = a_last_reg;
    end

    for (genvar k = 0; k < ITER_STAGES; k++)
    begin : g_iter
        logic signed [CORDIC_W-1:0] u_new;
        logic signed [CORDIC_W-1:0] v_new;
        logic signed [ANGLE_W-1:0]  z_new;
        logic [W+1:0]               rem_new;
        logic [W-1:0]               root_new;
        logic [2*W-1:0]             sq_new;

        if (k < CORDIC_STAGES)
        begin : g_rot
            logic signed [CORDIC_W-1:0] u_cur;
            logic signed [CORDIC_W-1:0] v_cur;
            logic signed [CORDIC_W-1:0] du;
            logic signed [CORDIC_W-1:0] dv;

            assign u_cur = iter_reg[k].u;
            assign v_cur = iter_reg[k].v;
            assign du    = v_cur >>> k;
            assign dv    = u_cur >>> k;

            // Drive v toward zero, accumulate the angle turned
            always_comb
            begin
                if (!v_cur[CORDIC_W-1])
                begin
                    u_new = u_cur + du;
                    v_new = v_cur - dv;
                    z_new = iter_reg[k].z + ATAN_HOURS[k];
                end
                else
                begin
                    u_new = u_cur - du;
                    v_new = v_cur + dv;
                    z_new = iter_reg[k].z - ATAN_HOURS[k];
                end
            end
        end
        else
        begin : g_rot_hold
            assign u_new = iter_reg[k].u;
            assign v_new = iter_reg[k].v;
            assign z_new = iter_reg[k].z;
        end

        if (k < W)
        begin : g_sqrt
            logic [W+1:0] acc;
            logic [W+1:0] trial;

            // Restoring square root: bring down two bits, try root*4+1
            assign acc    = {iter_reg[k].rem[W-1:0], iter_reg[k].sq[2*W-1:2*W-2]};
            assign trial  = {iter_reg[k].root, 2'b01};
            assign sq_new = {iter_reg[k].sq[2*W-3:0], 2'b00};

            always_comb
            begin
                if (acc >= trial)
                begin
                    rem_new  = acc - trial;
                    root_new = {iter_reg[k].root[W-2:0], 1'b1};
                end
                else
                begin
                    rem_new  = acc;
                    root_new = {iter_reg[k].root[W-2:0], 1'b0};
                end
            end
        end
        else
        begin : g_sqrt_hold
            assign rem_new  = iter_reg[k].rem;
            assign root_new = iter_reg[k].root;
            assign sq_new   = iter_reg[k].sq;
        end

        always_comb
        begin
            iter_next[k+1].u      = u_new;
            iter_next[k+1].v      = v_new;
            iter_next[k+1].z      = z_new;
            iter_next[k+1].sq     = sq_new;
            iter_next[k+1].rem    = rem_new;
            iter_next[k+1].root   = root_new;
            iter_next[k+1].origin = iter_reg[k].origin;
            iter_next[k+1].last   = iter_reg[k].last;
        end
    end

    for (genvar k = 0; k <= ITER_STAGES; k++)
    begin : g_stage
        logic up_valid;

        if (k == 0)
        begin : g_first
            assign up_valid = a_valid_reg;
        end
        else
        begin : g_rest
            assign up_valid = iter_valid_reg[k-1];
        end

        if (k == ITER_STAGES)
        begin : g_end
            assign iter_ready[k] = !iter_valid_reg[k] || f_ready;
        end
        else
        begin : g_mid
            assign iter_ready[k] = !iter_valid_reg[k] || iter_ready[k+1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                iter_valid_reg[k] <= 1'b0;
            else if (iter_ready[k])
                iter_valid_reg[k] <= up_valid;
        end

        always_ff @(posedge clk)
        begin
            if (iter_ready[k] && up_valid)
                iter_reg[k] <= iter_next[k];
        end
    end

    // ---------------- stage F: round radius, wrap angle ----------------
    iter_t                 last_iter;
    logic                  f_valid_reg;
    logic [W-1:0]          f_radius_reg, f_radius_next;
    logic [ANGLE_W-2:0]    f_time_reg, f_time_next;
    logic signed [ANGLE_W-1:0] t_wrap;
    logic                  f_origin_reg;
    logic                  f_last_reg;

    assign last_iter = iter_reg[ITER_STAGES];
    assign f_ready   = !f_valid_reg || out_ready;

    always_comb
    begin
        // Remainder above the root means the true root is nearer root + 1
        if (last_iter.rem > {2'b00, last_iter.root})
            f_radius_next = last_iter.root + 1'b1;
        else
            f_radius_next = last_iter.root;

        if (last_iter.z[ANGLE_W-1])
            t_wrap = last_iter.z + FULL_TURN;
        else
            t_wrap = last_iter.z;
        f_time_next = t_wrap[ANGLE_W-2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (f_ready)
            f_valid_reg <= iter_valid_reg[ITER_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (f_ready && iter_valid_reg[ITER_STAGES])
        begin
            f_radius_reg <= f_radius_next;
            f_time_reg   <= f_time_next;
            f_origin_reg <= last_iter.origin;
            f_last_reg   <= last_iter.last;
        end
    end

    // ---------------- output register: round the time ----------------
    logic               m_valid_reg;
    logic [W-1:0]       radius_reg;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic               last_reg;
    logic [ANGLE_W-2:0] time_sum;
    logic [TIME_W-1:0]  time_rnd;

    assign out_ready = !m_valid_reg || m_tready;
    assign time_sum  = f_time_reg + TIME_ROUND;
    assign time_rnd  = time_sum[ANGLE_W-2:ROUND_SHIFT];

    always_comb
    begin
        if (f_origin_reg)
            time_next = TIME_ORIGIN;
        else if (time_rnd >= TIME_LIMIT)
            time_next = '0;
        else
            time_next = time_rnd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_ready)
            m_valid_reg <= f_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && f_valid_reg)
        begin
            radius_reg <= f_radius_reg;
            time_reg   <= time_next;
            last_reg   <= f_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({time_reg, radius_reg});
    assign m_tlast  = last_reg;

    // ---------------- assertions ----------------
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> a_valid_reg)
        else $error("accepted request did not reach the first stage");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !iter_ready[0] |=> a_valid_reg && $stable(a_xx_reg) && $stable(a_u_reg))
        else $error("first stage changed while stalled");

    a_sqrt_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        iter_valid_reg[ITER_STAGES] |->
            (last_iter.rem <= ({2'b00, last_iter.root} << 1)))
        else $error("square root remainder out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> time_reg < TIME_LIMIT)
        else $error("local time not below 24 hours");

    a_origin_time: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid_reg && f_origin_reg && out_ready |=> m_valid_reg && time_reg == TIME_ORIGIN)
        else $error("origin did not give 12 hours");

endmodule

`default_nettype wire
